/* hw/rtl/sha1_pkg.sv */
// Shared types and constants for the SHA-1 digest core.
package sha1_pkg;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } sha1_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_RUN,
    ST_OUT
  } sha1_state_t;

endpackage

/* hw/rtl/sha1_message_digest_core.sv */
// Top level of the SHA-1 message digest core.
// Input stream: one item per transfer. in_tuser is the kind (0 = message
// byte, 1 = end of message); in_tdata carries the byte.
// Output stream: five transfers per end-of-message item, digest word 0
// first; out_tuser holds the word index, out_tlast marks word 4.
// Items pass through a four-entry queue into the hash engine, so the
// input can keep taking items while the engine compresses.
// Each data byte is written into the block buffer; every 64th byte starts
// the 80-round compression loop (one round per cycle), during which the
// engine takes no new item. End of message brings the remaining padding
// and length-byte writes, one or two compressions, then five output
// transfers. The engine holds its output word while out_tready is low and
// takes no new item until the digest is fully transferred; the queue
// then fills and in_tready drops.
// Reset (rst_n low, synchronous) loads the initial hash words, clears
// the byte count and empties the queue.
module sha1_message_digest_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast
);
  import sha1_pkg::*;

  sha1_item_t in_item, q_item;
  logic       q_valid, q_ready;

  assign in_item.kind = in_tuser;
  assign in_item.data = in_tdata;

  sha1_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(in_tvalid), .wr_ready(in_tready), .wr_item(in_item),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
  );

  sha1_engine u_engine (
    .clk(clk), .rst_n(rst_n),
    .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_word(out_tdata), .out_index(out_tuser), .out_last(out_tlast)
  );
endmodule

/* hw/rtl/sha1_fifo.sv */
// Small item queue between the input side and the hash engine.
module sha1_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  sha1_pkg::sha1_item_t wr_item,
  output logic                rd_valid,
  input  logic                rd_ready,
  output sha1_pkg::sha1_item_t rd_item
);
  import sha1_pkg::*;

  sha1_item_t mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = (cnt_r != 3'd4);
  assign rd_valid = (cnt_r != 3'd0);
  assign rd_item  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_item;
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 2'd1;
      if (rd) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'b0, wr} - {2'b0, rd};
    end
  end
endmodule

/* hw/rtl/sha1_engine.sv */
// Block buffer, padding sequencer, 80-round compression and digest output.
module sha1_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  sha1_pkg::sha1_item_t item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          out_word,
  output logic [2:0]           out_index,
  output logic                 out_last
);
  import sha1_pkg::*;

  sha1_state_t st_r, st_nxt;
  logic [31:0] w_r [16];
  logic [31:0] h_r [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [60:0] cnt_r;
  logic [5:0]  pos_r;
  logic [6:0]  rnd_r;
  logic        fin_r;
  logic        second_r;
  logic [2:0]  oi_r;
  logic [63:0] bits_r;

  logic        take, wr_en, rnd_done;
  logic [5:0]  wr_addr;
  logic [7:0]  wr_data;
  logic [31:0] fn, kc, tmp, wnew;

  assign take = item_valid && item_ready;
  assign item_ready = (st_r == ST_IDLE);
  assign rnd_done = (rnd_r == 7'd79);

  always_comb begin
    if (rnd_r < 7'd20) begin
      fn = (b_r & c_r) | (~b_r & d_r);
      kc = K0;
    end else if (rnd_r < 7'd40) begin
      fn = b_r ^ c_r ^ d_r;
      kc = K1;
    end else if (rnd_r < 7'd60) begin
      fn = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      kc = K2;
    end else begin
      fn = b_r ^ c_r ^ d_r;
      kc = K3;
    end
    tmp = {a_r[26:0], a_r[31:27]} + fn + e_r + kc + w_r[0];
    wnew = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
    wnew = {wnew[30:0], wnew[31]};
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (take) begin
          if (item.kind == KIND_END) begin
            if (pos_r == 6'd63) st_nxt = ST_RUN;
            else if (pos_r == 6'd55) st_nxt = ST_LEN;
            else st_nxt = ST_PAD;
          end else if (pos_r == 6'd63) begin
            st_nxt = ST_RUN;
          end
        end
      end
      ST_PAD: begin
        if (pos_r == 6'd63 && second_r) st_nxt = ST_RUN;
        else if (pos_r == 6'd55 && !second_r) st_nxt = ST_LEN;
      end
      ST_LEN:  if (pos_r == 6'd63) st_nxt = ST_RUN;
      ST_RUN: begin
        if (rnd_done) begin
          if (!fin_r) st_nxt = ST_IDLE;
          else if (second_r) st_nxt = ST_PAD;
          else st_nxt = ST_OUT;
        end
      end
      ST_OUT:  if (out_ready && oi_r == 3'd4) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = pos_r;
    wr_data = '0;
    case (st_r)
      ST_IDLE: begin
        wr_en = take;
        wr_data = (item.kind == KIND_END) ? PAD_BYTE : item.data;
      end
      ST_PAD:  wr_en = 1'b1;
      ST_LEN: begin
        wr_en = 1'b1;
        wr_data = bits_r[{~pos_r[2:0], 3'b000} +: 8];
      end
      default: wr_en = 1'b0;
    endcase
  end

  assign out_valid = (st_r == ST_OUT);
  assign out_word  = h_r[oi_r];
  assign out_index = oi_r;
  assign out_last  = (oi_r == 3'd4);

  // message bytes land big-endian straight in the schedule words
  always_ff @(posedge clk) begin
    if (wr_en) w_r[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <= wr_data;
    if (st_nxt == ST_RUN && st_r != ST_RUN) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end else if (st_r == ST_RUN) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wnew;
      a_r <= tmp;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
    if (!rst_n) begin
      st_r <= ST_IDLE;
      h_r[0] <= H0; h_r[1] <= H1; h_r[2] <= H2; h_r[3] <= H3; h_r[4] <= H4;
      cnt_r <= '0;
      pos_r <= '0;
      rnd_r <= '0;
      fin_r <= 1'b0;
      second_r <= 1'b0;
      oi_r <= '0;
      bits_r <= '0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        ST_IDLE: begin
          if (take) begin
            pos_r <= pos_r + 6'd1;
            if (item.kind == KIND_END) begin
              fin_r <= 1'b1;
              bits_r <= {cnt_r, 3'b000};
              second_r <= (pos_r > 6'd55);
            end else begin
              cnt_r <= cnt_r + 61'd1;
              fin_r <= 1'b0;
            end
          end
        end
        ST_PAD, ST_LEN: pos_r <= pos_r + 6'd1;
        ST_RUN: begin
          rnd_r <= rnd_r + 7'd1;
          if (rnd_done) begin
            rnd_r <= '0;
            h_r[0] <= h_r[0] + tmp;
            h_r[1] <= h_r[1] + a_r;
            h_r[2] <= h_r[2] + {b_r[1:0], b_r[31:2]};
            h_r[3] <= h_r[3] + c_r;
            h_r[4] <= h_r[4] + d_r;
            if (fin_r && second_r) second_r <= 1'b0;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            oi_r <= oi_r + 3'd1;
            if (oi_r == 3'd4) begin
              oi_r <= '0;
              h_r[0] <= H0; h_r[1] <= H1; h_r[2] <= H2; h_r[3] <= H3; h_r[4] <= H4;
              cnt_r <= '0;
              pos_r <= '0;
              fin_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
